@@ sv/sacl_pkg.sv @@
`timescale 1ns / 1ps
package sacl_pkg;

  // widths of the fixed fields
  localparam int OUTCOME_W    = 2;
  localparam int SET_OUT_W    = 6;
  localparam int WAY_OUT_W    = 2;
  localparam int SET_BITS_W   = 3;
  localparam int BLOCK_BITS_W = 5;
  localparam int WAYS_W       = 3;
  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 5;

  typedef logic [OUTCOME_W-1:0] outcome_t;

  // outcome codes
  localparam outcome_t OUTCOME_HIT   = 2'd0;
  localparam outcome_t OUTCOME_FILL  = 2'd1;
  localparam outcome_t OUTCOME_EVICT = 2'd2;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_SET_BITS    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_BITS  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_WAYS_IN_USE = 2'd2;

  localparam logic [WAYS_W-1:0] WAYS_RESET = 3'd4;

  // one result item
  typedef struct packed {
    outcome_t               outcome;
    logic [SET_OUT_W-1:0]   set_index;
    logic [WAY_OUT_W-1:0]   way;
  } result_t;

endpackage

@@ sv/sacl_if.sv @@
`timescale 1ns / 1ps
interface sacl_in_if #(
  parameter int ADDR_WIDTH = 48
);
  logic                  valid;
  logic                  ready;
  logic [ADDR_WIDTH-1:0] address;

  modport source (output valid, output address, input ready);
  modport sink (input valid, input address, output ready);
endinterface

interface sacl_out_if import sacl_pkg::*;;
  logic                 valid;
  logic                 ready;
  outcome_t             outcome;
  logic [SET_OUT_W-1:0] set_index;
  logic [WAY_OUT_W-1:0] way;

  modport source (output valid, output outcome, output set_index, output way, input ready);
  modport sink (input valid, input outcome, input set_index, input way, output ready);
endinterface

@@ sv/sacl_mem.sv @@
`timescale 1ns / 1ps
module sacl_mem #(
  parameter int ADDR_W = 6,
  parameter int ROW_W  = 200
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [ROW_W-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [ROW_W-1:0]  rdata
);

  localparam int DEPTH = 1 << ADDR_W;

  logic [ROW_W-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/sacl_pick.sv @@
`timescale 1ns / 1ps
module sacl_pick import sacl_pkg::*; #(
  parameter int MAX_WAYS   = 4,
  parameter int ADDR_WIDTH = 48,
  parameter int AGE_W      = 2,
  parameter int WAY_W      = 2,
  parameter int CNT_W      = 3
) (
  input  logic [MAX_WAYS-1:0]                  row_valid,
  input  logic [MAX_WAYS*(ADDR_WIDTH+AGE_W)-1:0] row_data,
  input  logic [ADDR_WIDTH-1:0]                tag,
  input  logic [CNT_W-1:0]                     ways,
  output outcome_t                             outcome,
  output logic [WAY_W-1:0]                     chosen,
  output logic [MAX_WAYS-1:0]                  new_valid,
  output logic [MAX_WAYS*(ADDR_WIDTH+AGE_W)-1:0] new_row
);

  localparam int LINE_W = ADDR_WIDTH + AGE_W;
  localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(MAX_WAYS - 1);

  logic [ADDR_WIDTH-1:0] line_tag [MAX_WAYS];
  logic [AGE_W-1:0]      line_age [MAX_WAYS];
  logic [MAX_WAYS-1:0]   in_use;
  logic [MAX_WAYS-1:0]   hit_vec;
  logic [MAX_WAYS-1:0]   empty_vec;
  logic [WAY_W-1:0]      hit_way;
  logic [WAY_W-1:0]      empty_way;
  logic [WAY_W-1:0]      victim_way;
  logic [AGE_W-1:0]      oldest;
  logic [AGE_W-1:0]      limit;
  logic                  age_all;

  // unpack the row and find hit / empty candidates
  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      line_tag[w]  = row_data[w*LINE_W +: ADDR_WIDTH];
      line_age[w]  = row_data[w*LINE_W + ADDR_WIDTH +: AGE_W];
      in_use[w]    = (w < int'(ways));
      hit_vec[w]   = in_use[w] && row_valid[w] && (line_tag[w] == tag);
      empty_vec[w] = in_use[w] && !row_valid[w];
    end
  end

  // lowest-numbered hit and empty way
  always_comb begin
    hit_way   = '0;
    empty_way = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (hit_vec[w]) begin
        hit_way = WAY_W'(w);
      end
      if (empty_vec[w]) begin
        empty_way = WAY_W'(w);
      end
    end
  end

  // lru victim: lowest-numbered way with the largest age
  always_comb begin
    oldest     = line_age[0];
    victim_way = '0;
    for (int w = 1; w < MAX_WAYS; w++) begin
      if (in_use[w] && line_age[w] > oldest) begin
        oldest     = line_age[w];
        victim_way = WAY_W'(w);
      end
    end
  end

  // outcome, chosen way and aging rule
  always_comb begin
    if (|hit_vec) begin
      outcome = OUTCOME_HIT;
      chosen  = hit_way;
      limit   = line_age[hit_way];
      age_all = 1'b0;
    end else if (|empty_vec) begin
      outcome = OUTCOME_FILL;
      chosen  = empty_way;
      limit   = '0;
      age_all = 1'b1;
    end else begin
      outcome = OUTCOME_EVICT;
      chosen  = victim_way;
      limit   = oldest;
      age_all = 1'b0;
    end
  end

  // new row: chosen way gets the tag and age 0, others may age
  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (WAY_W'(w) == chosen) begin
        new_row[w*LINE_W +: ADDR_WIDTH]         = tag;
        new_row[w*LINE_W + ADDR_WIDTH +: AGE_W] = '0;
        new_valid[w]                            = 1'b1;
      end else begin
        new_row[w*LINE_W +: ADDR_WIDTH] = line_tag[w];
        new_valid[w]                    = row_valid[w];
        if (in_use[w] && row_valid[w] && (age_all || line_age[w] < limit)
            && line_age[w] < AGE_MAX) begin
          new_row[w*LINE_W + ADDR_WIDTH +: AGE_W] = line_age[w] + 1'b1;
        end else begin
          new_row[w*LINE_W + ADDR_WIDTH +: AGE_W] = line_age[w];
        end
      end
    end
  end

endmodule

@@ sv/set_associative_cache_lookup.sv @@
`timescale 1ns / 1ps
// Set-associative cache tag lookup with true LRU replacement.
// in_ch carries one block address per item; out_ch returns one result per
// item: outcome (hit, fill of an empty way, eviction), set index and way.
// Both channels use valid/ready; an item moves when both are high.
// The configuration port (cfg_we, cfg_index, cfg_data) sets set_bits,
// block_bits and ways_in_use; write it only while no item is in flight.
// Tags and ages live in one row-wide memory (one row per set, registered
// read); valid bits are flip-flops per line, read registered.
// The edge that takes an item reads the set; the lookup step then picks
// the way, writes the row back and fills the result register. No new item
// is taken until the lookup step finishes.
// A new item is accepted while a result still waits in the output register;
// if the receiver stalls and the next item is ready to finish, it holds in
// the lookup step and no further item is taken until the result drains.
// Reset (rst, synchronous) marks all lines invalid and returns the
// registers to set_bits 0, block_bits 0, ways_in_use 4. No clearing pass;
// no item is taken while reset is high.
module set_associative_cache_lookup import sacl_pkg::*; #(
  parameter int MAX_SET_BITS = 6,
  parameter int MAX_WAYS     = 4,
  parameter int ADDR_WIDTH   = 48
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  sacl_in_if.sink                in_ch,
  sacl_out_if.source             out_ch
);

  localparam int SETS    = 1 << MAX_SET_BITS;
  localparam int SET_W   = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int AGE_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WAY_W   = AGE_W;
  localparam int CNT_W   = $clog2(MAX_WAYS + 1);
  localparam int ROW_W   = MAX_WAYS * (ADDR_WIDTH + AGE_W);
  localparam int SHIFT_W = $clog2((1 << BLOCK_BITS_W) + MAX_SET_BITS + 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_LOOK = 1'b1;

  logic                    state;
  logic [SET_BITS_W-1:0]   set_bits;
  logic [BLOCK_BITS_W-1:0] block_bits;
  logic [WAYS_W-1:0]       ways_in_use;

  logic [SHIFT_W-1:0]    sb_eff;
  logic [CNT_W-1:0]      ways_eff;
  logic [ADDR_WIDTH-1:0] set_full;
  logic [SET_W-1:0]      set_val;
  logic [ADDR_WIDTH-1:0] tag_val;

  logic [SET_W-1:0]      set_q;
  logic [ADDR_WIDTH-1:0] tag_q;
  logic [CNT_W-1:0]      ways_q;
  logic [MAX_WAYS-1:0]   row_valid_q;

  logic [MAX_WAYS-1:0] line_valid [SETS];
  logic [ROW_W-1:0]    rd_row;
  logic [ROW_W-1:0]    new_row;
  logic [MAX_WAYS-1:0] new_valid;
  outcome_t            pick_outcome;
  logic [WAY_W-1:0]    pick_way;

  logic    in_take;
  logic    finish;
  logic    out_valid;
  result_t result;

  logic [SET_W+SET_OUT_W-1:0] set_ext;
  logic [WAY_W+WAY_OUT_W-1:0] way_ext;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      set_bits    <= '0;
      block_bits  <= '0;
      ways_in_use <= WAYS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SET_BITS:    set_bits    <= cfg_data[SET_BITS_W-1:0];
        REG_BLOCK_BITS:  block_bits  <= cfg_data[BLOCK_BITS_W-1:0];
        REG_WAYS_IN_USE: ways_in_use <= cfg_data[WAYS_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp the configuration and split the address
  always_comb begin
    if (int'(set_bits) > MAX_SET_BITS) begin
      sb_eff = SHIFT_W'(MAX_SET_BITS);
    end else begin
      sb_eff = SHIFT_W'(set_bits);
    end
    if (ways_in_use == '0) begin
      ways_eff = CNT_W'(1);
    end else if (int'(ways_in_use) > MAX_WAYS) begin
      ways_eff = CNT_W'(MAX_WAYS);
    end else begin
      ways_eff = CNT_W'(ways_in_use);
    end
    set_full = in_ch.address >> block_bits;
    set_val  = set_full[SET_W-1:0] & ~({SET_W{1'b1}} << sb_eff);
    tag_val  = in_ch.address >> (SHIFT_W'(block_bits) + sb_eff);
  end

  assign in_ch.ready = (state == ST_IDLE) && !rst;
  assign in_take     = in_ch.valid && in_ch.ready;
  assign finish      = (state == ST_LOOK) && (!out_valid || out_ch.ready);

  // control: read the set, then pick and write back
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_take) begin
            state <= ST_LOOK;
          end
        end
        ST_LOOK: begin
          if (finish) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // item registers, valid bits of the set read alongside the memory
  always_ff @(posedge clk) begin
    if (in_take) begin
      set_q       <= set_val;
      tag_q       <= tag_val;
      ways_q      <= ways_eff;
      row_valid_q <= line_valid[set_val];
    end
  end

  // per-line valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < SETS; s++) begin
        line_valid[s] <= '0;
      end
    end else if (finish) begin
      line_valid[set_q] <= new_valid;
    end
  end

  // tag and age rows
  sacl_mem #(
    .ADDR_W (SET_W),
    .ROW_W  (ROW_W)
  ) u_mem (
    .clk   (clk),
    .we    (finish),
    .waddr (set_q),
    .wdata (new_row),
    .re    (in_take),
    .raddr (set_val),
    .rdata (rd_row)
  );

  // hit search, victim choice and age update
  sacl_pick #(
    .MAX_WAYS   (MAX_WAYS),
    .ADDR_WIDTH (ADDR_WIDTH),
    .AGE_W      (AGE_W),
    .WAY_W      (WAY_W),
    .CNT_W      (CNT_W)
  ) u_pick (
    .row_valid (row_valid_q),
    .row_data  (rd_row),
    .tag       (tag_q),
    .ways      (ways_q),
    .outcome   (pick_outcome),
    .chosen    (pick_way),
    .new_valid (new_valid),
    .new_row   (new_row)
  );

  assign set_ext = {{SET_OUT_W{1'b0}}, set_q};
  assign way_ext = {{WAY_OUT_W{1'b0}}, pick_way};

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      result.outcome   <= pick_outcome;
      result.set_index <= set_ext[SET_OUT_W-1:0];
      result.way       <= way_ext[WAY_OUT_W-1:0];
    end
  end

  assign out_ch.valid     = out_valid;
  assign out_ch.outcome   = result.outcome;
  assign out_ch.set_index = result.set_index;
  assign out_ch.way       = result.way;

endmodule
